>>> sv/srtp_rollover_replay_tracker_assert.svh
// Assertion macros for the SRTP rollover and replay tracker.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef SRTP_ROLLOVER_REPLAY_TRACKER_ASSERT_SVH
`define SRTP_ROLLOVER_REPLAY_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRTP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("srtp tracker assertion failed");
`define SRTP_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define SRTP_ASSERT(label, prop)
`define SRTP_ASSERT_MSG(label, prop, msg)
`endif
`endif

>>> sv/srtp_pkg.sv
// Types, widths and codes shared by the SRTP rollover and replay tracker.
// No dependencies.
`default_nettype none
package srtp_pkg;

  localparam int unsigned WINDOW_SIZE = 64;
  localparam int unsigned WinIdxW     = $clog2(WINDOW_SIZE);
  localparam int unsigned SeqW        = 16;
  localparam int unsigned RocW        = 32;
  localparam int unsigned HalfRange   = 32768;

  typedef enum logic {
    OP_CHECK  = 1'b0,
    OP_COMMIT = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    VERDICT_FRESH = 2'd0,
    VERDICT_SEEN  = 2'd1,
    VERDICT_OLD   = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [SeqW-1:0]        highest;
    logic [RocW-1:0]        roc;
    logic [WINDOW_SIZE-1:0] bitmap;
  } stream_state_t;

  typedef struct packed {
    verdict_e        verdict;
    logic [RocW-1:0] roc;
  } result_t;

endpackage
`default_nettype wire

>>> sv/srtp_if.sv
// Valid/ready channel interfaces for the SRTP tracker: packet items in, results out.
// Depends on srtp_pkg.
`default_nettype none
interface srtp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [srtp_pkg::SeqW-1:0] seq_number;

  modport source (output valid, output opcode, output seq_number, input ready);
  modport sink   (input valid, input opcode, input seq_number, output ready);
endinterface

interface srtp_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                verdict;
  logic [srtp_pkg::RocW-1:0] rollover_value;

  modport source (output valid, output verdict, output rollover_value, input ready);
  modport sink   (input valid, input verdict, input rollover_value, output ready);
endinterface
`default_nettype wire

>>> sv/srtp_classify.sv
// Classification and state update for one packet item against the stream state.
// Purely combinational; depends on srtp_pkg.
`default_nettype none
module srtp_classify (
  input  srtp_pkg::stream_state_t     st_i,
  input  logic                        opcode_i,
  input  logic [srtp_pkg::SeqW-1:0]   seq_i,
  output srtp_pkg::result_t           res_o,
  output srtp_pkg::stream_state_t     st_o
);
  import srtp_pkg::*;

  logic [SeqW-1:0]        delta;
  logic [SeqW-1:0]        back;
  logic                   ahead;
  logic                   in_window;
  logic                   near_ahead;
  logic                   seen_bit;
  logic [WinIdxW-1:0]     back_idx;
  logic [WinIdxW-1:0]     shift_amt;
  logic [RocW-1:0]        roc;
  verdict_e               verdict;
  logic [WINDOW_SIZE-1:0] shifted;

  always_comb begin
    delta      = seq_i - st_i.highest;
    back       = SeqW'(0) - delta;
    ahead      = (delta != '0) && (delta < SeqW'(HalfRange));
    in_window  = back < SeqW'(WINDOW_SIZE);
    near_ahead = delta < SeqW'(WINDOW_SIZE);
    back_idx   = back[WinIdxW-1:0];
    shift_amt  = delta[WinIdxW-1:0];
    seen_bit   = in_window && st_i.bitmap[back_idx];

    roc     = st_i.roc;
    verdict = VERDICT_FRESH;
    if (ahead) begin
      if (seq_i < st_i.highest) begin
        roc = st_i.roc + RocW'(1);
      end
    end else if (!in_window) begin
      verdict = VERDICT_OLD;
    end else if (seen_bit) begin
      verdict = VERDICT_SEEN;
    end

    shifted = near_ahead ? (st_i.bitmap << shift_amt) : '0;

    st_o = st_i;
    if ((opcode_i == OP_COMMIT) && (verdict == VERDICT_FRESH)) begin
      if (ahead) begin
        st_o.bitmap  = shifted | WINDOW_SIZE'(1);
        st_o.highest = seq_i;
        st_o.roc     = roc;
      end else begin
        st_o.bitmap[back_idx] = 1'b1;
      end
    end

    res_o.verdict = verdict;
    res_o.roc     = roc;
  end

endmodule
`default_nettype wire

>>> sv/srtp_rollover_replay_tracker.sv
// SRTP receive-side replay tracker: one stream's highest sequence number, rollover
// counter and replay bitmap. Each item (check or commit) gives one result; it passes
// the input register, then the result register. One item is taken every cycle while
// the output is not stalled. The rate is set by the loop from the state registers
// through classification back into state; a stalled output stalls the input side too.
// Depends on srtp_pkg, srtp_if, srtp_classify and the assertion header.
`default_nettype none
`include "srtp_rollover_replay_tracker_assert.svh"
module srtp_rollover_replay_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  srtp_in_if.sink    in_i,
  srtp_out_if.source out_o
);
  import srtp_pkg::*;

  logic            in_valid_q;
  logic            in_op_q;
  logic [SeqW-1:0] in_seq_q;
  logic            out_valid_q;
  verdict_e        out_verdict_q;
  logic [RocW-1:0] out_roc_q;
  stream_state_t   st_q;
  stream_state_t   st_d;
  result_t         res;
  logic            advance;
  logic            fire;

  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  srtp_classify u_classify (
    .st_i     (st_q),
    .opcode_i (in_op_q),
    .seq_i    (in_seq_q),
    .res_o    (res),
    .st_o     (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_op_q  <= in_i.opcode;
      in_seq_q <= in_i.seq_number;
    end
    if (fire) begin
      out_verdict_q <= res.verdict;
      out_roc_q     <= res.roc;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.verdict        = out_verdict_q;
  assign out_o.rollover_value = out_roc_q;

  `SRTP_ASSERT(a_roc_monotonic, 1 |=> (st_q.roc == $past(st_q.roc) || st_q.roc == $past(st_q.roc) + RocW'(1)))
  `SRTP_ASSERT(a_new_highest_marked, (st_q.highest != $past(st_q.highest)) |-> st_q.bitmap[0])
  `SRTP_ASSERT_MSG(a_state_only_on_commit, !(fire && in_op_q == OP_COMMIT) |=> $stable(st_q), "state changed without a commit")
  `SRTP_ASSERT_MSG(a_result_from_input, (out_valid_q && !$past(out_valid_q)) |-> $past(in_valid_q), "result without an input item")

endmodule
`default_nettype wire

>>> sim/tb.sv
// Testbench for srtp_rollover_replay_tracker: directed and random check/commit packets.
// A predictor class tracks highest number, rollover counter and replay bitmap and
// checks every result. Depends on srtp_pkg, srtp_if and the tracker RTL.
module tb;
  import srtp_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 1200;

  class stream_replay_predictor;
    logic [SeqW-1:0]        highest;
    logic [RocW-1:0]        roc;
    logic [WINDOW_SIZE-1:0] bitmap;
    result_t                pending_verdicts[$];
    int unsigned            mismatches;

    function new();
      highest    = '0;
      roc        = '0;
      bitmap     = '0;
      mismatches = 0;
    endfunction

    function void note_packet(opcode_e op, logic [SeqW-1:0] seq);
      logic [SeqW-1:0] delta;
      logic [SeqW-1:0] back;
      bit              ahead;
      logic [RocW-1:0] roc_next;
      result_t         res;
      delta    = seq - highest;
      ahead    = (delta != 0) && (delta < HalfRange);
      roc_next = roc;
      back     = '0;
      res.verdict = VERDICT_FRESH;
      if (ahead) begin
        if (seq < highest) roc_next = roc + RocW'(1);
      end else begin
        back = 16'(0) - delta;
        if (back >= WINDOW_SIZE) res.verdict = VERDICT_OLD;
        else if (bitmap[back[WinIdxW-1:0]]) res.verdict = VERDICT_SEEN;
      end
      if (op == OP_COMMIT && res.verdict == VERDICT_FRESH) begin
        if (ahead) begin
          if (delta >= WINDOW_SIZE) bitmap = '0;
          else bitmap = bitmap << delta;
          bitmap[0] = 1'b1;
          highest   = seq;
          roc       = roc_next;
        end else begin
          bitmap[back[WinIdxW-1:0]] = 1'b1;
        end
      end
      res.roc = roc_next;
      pending_verdicts.push_back(res);
    endfunction

    function void check_result(logic [1:0] verdict, logic [RocW-1:0] roc_value);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict %0d roc %0h", verdict, roc_value);
        return;
      end
      want = pending_verdicts.pop_front();
      if (verdict !== want.verdict || roc_value !== want.roc) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: verdict exp %0d got %0d, roc exp %0h got %0h",
                   want.verdict, verdict, want.roc, roc_value);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   quiet;
  int unsigned items_sent;

  stream_replay_predictor sb = new();

  srtp_in_if  in_bus ();
  srtp_out_if out_bus ();

  srtp_rollover_replay_tracker u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic send_item(input opcode_e op, input logic [SeqW-1:0] seq);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.seq_number <= seq;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_packet(op, seq);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_bus.ready <= 1'b0;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        @(negedge clk_i);
        out_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      sb.check_result(out_bus.verdict, out_bus.rollover_value);
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle = 0;
      else idle++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : packet_source
    int unsigned     packet_no;
    int unsigned     kind;
    int unsigned     pattern;
    logic [SeqW-1:0] seq;
    bit              paused;
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= OP_CHECK;
    in_bus.seq_number <= '0;
    rst_ni            <= 1'b0;
    quiet             = 1'b0;
    items_sent        = 0;
    paused            = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(OP_CHECK,  16'd0);
    send_item(OP_COMMIT, 16'd0);
    send_item(OP_CHECK,  16'd0);
    send_item(OP_COMMIT, 16'd0);
    send_item(OP_COMMIT, 16'd1);
    send_item(OP_CHECK,  16'd65535);
    send_item(OP_COMMIT, 16'd65535);
    send_item(OP_CHECK,  16'd65535);
    send_item(OP_COMMIT, 16'd64);
    send_item(OP_COMMIT, 16'd128);
    send_item(OP_CHECK,  16'd65);
    send_item(OP_CHECK,  16'd64);
    send_item(OP_COMMIT, 16'd64);
    send_item(OP_COMMIT, 16'd32895);
    send_item(OP_CHECK,  16'd127);
    send_item(OP_COMMIT, 16'd65535);
    send_item(OP_CHECK,  16'd0);
    send_item(OP_COMMIT, 16'd0);
    send_item(OP_CHECK,  16'd65535);
    send_item(OP_COMMIT, 16'd65500);
    send_item(OP_COMMIT, 16'd40);
    send_item(OP_CHECK,  16'd65500);
    send_item(OP_COMMIT, 16'd32808);
    drain_results();

    packet_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = ((packet_no % 200) >= 160);
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 40)      seq = sb.highest + 16'($urandom_range(1, 70));
      else if (kind < 65) seq = sb.highest - 16'($urandom_range(0, 63));
      else if (kind < 75) seq = sb.highest + 16'($urandom_range(64, 32767));
      else if (kind < 85) seq = sb.highest - 16'($urandom_range(64, 32768));
      else                seq = 16'($urandom_range(0, 65535));
      pattern = $urandom_range(0, 9);
      if (pattern != 6 && pattern != 7) send_item(OP_CHECK, seq);
      if (pattern != 8) send_item(OP_COMMIT, seq);
      if (pattern == 9) send_item(OP_COMMIT, seq);
      packet_no++;
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b0;

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
